// ===== rtl/core/fsr_pkg.sv =====
// Shared types and constants of the Schlick Fresnel reflectance pipeline.
// Used by fresnel_schlick_reflectance and the testbench; it depends on nothing else.

package fsr_pkg;

  typedef struct packed {
    logic signed [15:0] eye_x;
    logic signed [15:0] eye_y;
    logic signed [15:0] eye_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [14:0]        index_from;
    logic [14:0]        index_to;
  } req_t;

  typedef struct packed {
    logic [15:0] reflectance;
    logic        total_internal;
  } res_t;

  localparam int unsigned FracBits = 28;
  localparam int unsigned QuoBits  = 29;
  localparam logic [15:0] ReflOne  = 16'd32768;

endpackage

// ===== rtl/core/fsr_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Carries a valid bit and a sideband word alongside; uses no package items.

module fsr_div_pipe #(
  parameter int unsigned NumW  = 59,
  parameter int unsigned DenW  = 30,
  parameter int unsigned QuoW  = 29,
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [QuoW-1:0]  quo_o,
  output logic [SideW-1:0] side_o
);

  logic             valid_q [QuoW];
  logic [NumW-1:0]  rem_q   [QuoW];
  logic [DenW-1:0]  den_q   [QuoW];
  logic [QuoW-1:0]  quo_q   [QuoW];
  logic [SideW-1:0] side_q  [QuoW];

  for (genvar k = 0; k < QuoW; k++) begin : g_stage
    localparam int unsigned Bit = QuoW - 1 - k;
    logic             v_in;
    logic [NumW-1:0]  rem_in;
    logic [NumW-1:0]  trial;
    logic [DenW-1:0]  den_in;
    logic [QuoW-1:0]  quo_in;
    logic [SideW-1:0] side_in;

    if (k == 0) begin : g_head
      assign v_in    = valid_i;
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign side_in = side_i;
    end else begin : g_body
      assign v_in    = valid_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = NumW'(den_in) << Bit;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      den_q[k]  <= den_in;
      side_q[k] <= side_in;
      if (rem_in >= trial) begin
        rem_q[k] <= rem_in - trial;
        quo_q[k] <= quo_in | (QuoW'(1) << Bit);
      end else begin
        rem_q[k] <= rem_in;
        quo_q[k] <= quo_in;
      end
    end
  end

  assign valid_o = valid_q[QuoW-1];
  assign quo_o   = quo_q[QuoW-1];
  assign side_o  = side_q[QuoW-1];

endmodule

// ===== rtl/core/fsr_sqrt_pipe.sv =====
// Pipelined integer square root, one root bit per register stage.
// Carries a valid bit and a sideband word alongside; uses no package items.

module fsr_sqrt_pipe #(
  parameter int unsigned RootW = 29,
  parameter int unsigned SideW = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [2*RootW-1:0] rad_i,
  input  logic [SideW-1:0]   side_i,
  output logic               valid_o,
  output logic [RootW-1:0]   root_o,
  output logic [SideW-1:0]   side_o
);

  localparam int unsigned RadW = 2 * RootW;

  logic             valid_q [RootW];
  logic [RadW-1:0]  rem_q   [RootW];
  logic [RootW-1:0] root_q  [RootW];
  logic [SideW-1:0] side_q  [RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    localparam int unsigned Bit = RootW - 1 - k;
    logic             v_in;
    logic [RadW-1:0]  rem_in;
    logic [RadW-1:0]  trial;
    logic [RootW-1:0] root_in;
    logic [SideW-1:0] side_in;

    if (k == 0) begin : g_head
      assign v_in    = valid_i;
      assign rem_in  = rad_i;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_body
      assign v_in    = valid_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = (RadW'(root_in) << (Bit + 1)) | (RadW'(1) << (2 * Bit));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[k] <= side_in;
      if (rem_in >= trial) begin
        rem_q[k]  <= rem_in - trial;
        root_q[k] <= root_in | (RootW'(1) << Bit);
      end else begin
        rem_q[k]  <= rem_in;
        root_q[k] <= root_in;
      end
    end
  end

  assign valid_o = valid_q[RootW-1];
  assign root_o  = root_q[RootW-1];
  assign side_o  = side_q[RootW-1];

endmodule

// ===== rtl/core/fresnel_schlick_reflectance.sv =====
// Top level of the Schlick Fresnel reflectance pipeline.
// Depends on fsr_pkg, fsr_div_pipe and fsr_sqrt_pipe.
//
//   channel   ports                      handshake
//   request   req_i                      taken when start_i is high and busy_o low
//   result    res_o                      valid for the one cycle done_o is high
//
// A request is taken in every cycle in which start_i is high; busy_o is never raised.
// Results appear in request order.
// Five input stages, the two 29-stage dividers side by side, the 29-stage square root
// and eight further stages make up the latency.
// Reset clears the valid bits only; requests in flight are dropped.
// The receiver cannot stall, so nothing inside the pipeline ever holds.

module fresnel_schlick_reflectance (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  fsr_pkg::req_t req_i,
  output logic          busy_o,
  output logic          done_o,
  output fsr_pkg::res_t res_o
);

  localparam int unsigned Q       = fsr_pkg::FracBits;
  localparam int unsigned QW      = fsr_pkg::QuoBits;
  localparam int unsigned Latency = 71;

  localparam logic signed [33:0] DotMax = 34'sd268435456;
  localparam logic signed [29:0] COne   = 30'sd268435456;
  localparam logic [56:0]        OneSq  = 57'd1 << 56;
  localparam logic [57:0]        OneRad = 58'd1 << Q;
  localparam logic [28:0]        OneX   = 29'd1 << Q;

  typedef struct packed {
    logic               gt;
    logic               n2z;
    logic               sz;
    logic signed [29:0] c;
    logic [29:0]        n1sq;
    logic [29:0]        n2sq;
    logic [14:0]        d;
    logic [15:0]        sum;
  } car_t;

  typedef struct packed {
    logic               tir;
    logic               gt;
    logic               n2z;
    logic signed [29:0] c;
  } side_a_t;

  typedef struct packed {
    logic               tir;
    logic               gt;
    logic signed [29:0] c;
    logic [28:0]        r0;
  } side_r_t;

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Stage 1: component products.
  logic               v1_q;
  logic signed [31:0] px_q, py_q, pz_q;
  logic [14:0]        n1_q, n2_q;

  // Stage 2: saturated cosine and index terms.
  logic               v2_q;
  car_t               car2_q;
  logic signed [33:0] dot;
  logic signed [29:0] c_sat;
  logic [14:0]        n1_n2, n2_n1;

  // Stages 3 to 5: sine squared of the incident angle, then scaled by n1 squared.
  logic               v3_q, v4_q, v5_q;
  car_t               car3_q, car4_q, car5_q;
  logic signed [29:0] c_neg;
  logic [56:0]        acsq_q;
  logic [56:0]        si_full;
  logic [28:0]        si_q;
  logic [58:0]        lhs_q;
  logic               tir5;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  assign dot   = 34'(px_q) + 34'(py_q) + 34'(pz_q);
  assign c_sat = (dot > DotMax) ? COne : ((dot < -DotMax) ? -COne : dot[29:0]);
  assign n1_n2 = n1_q - n2_q;
  assign n2_n1 = n2_q - n1_q;
  assign c_neg = (car2_q.c < 0) ? -car2_q.c : car2_q.c;
  assign si_full = OneSq - acsq_q;

  always_ff @(posedge clk_i) begin
    px_q   <= req_i.eye_x * req_i.norm_x;
    py_q   <= req_i.eye_y * req_i.norm_y;
    pz_q   <= req_i.eye_z * req_i.norm_z;
    n1_q   <= req_i.index_from;
    n2_q   <= req_i.index_to;

    car2_q.gt   <= n1_q > n2_q;
    car2_q.n2z  <= n2_q == 15'd0;
    car2_q.sz   <= (16'(n1_q) + 16'(n2_q)) == 16'd0;
    car2_q.c    <= c_sat;
    car2_q.n1sq <= 30'(n1_q) * 30'(n1_q);
    car2_q.n2sq <= 30'(n2_q) * 30'(n2_q);
    car2_q.d    <= (n1_q > n2_q) ? n1_n2 : n2_n1;
    car2_q.sum  <= 16'(n1_q) + 16'(n2_q);

    car3_q <= car2_q;
    acsq_q <= 57'(c_neg[28:0]) * 57'(c_neg[28:0]);

    car4_q <= car3_q;
    si_q   <= si_full[56:28];

    car5_q <= car4_q;
    lhs_q  <= 59'(car4_q.n1sq) * 59'(si_q);
  end

  assign tir5 = car5_q.gt && (lhs_q > (59'(car5_q.n2sq) << Q));

  // Transmitted sine squared and the r0 quotient, side by side.
  side_a_t     side_a_in, side_a_out;
  logic        va, vb, sz_b;
  logic [QW-1:0] quo_a, quo_b;

  assign side_a_in = '{tir: tir5, gt: car5_q.gt, n2z: car5_q.n2z, c: car5_q.c};

  fsr_div_pipe #(
    .NumW (59),
    .DenW (30),
    .QuoW (QW),
    .SideW($bits(side_a_t))
  ) u_div_sin (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v5_q),
    .num_i  (lhs_q),
    .den_i  (car5_q.n2sq),
    .side_i (side_a_in),
    .valid_o(va),
    .quo_o  (quo_a),
    .side_o (side_a_out)
  );

  fsr_div_pipe #(
    .NumW (44),
    .DenW (16),
    .QuoW (QW),
    .SideW(1)
  ) u_div_r0 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v5_q),
    .num_i  (44'(car5_q.d) << Q),
    .den_i  (car5_q.sum),
    .side_i (car5_q.sz),
    .valid_o(vb),
    .quo_o  (quo_b),
    .side_o (sz_b)
  );

  // Stage 7: radicand of the transmitted cosine and r0.
  logic        v7_q;
  logic [57:0] rad_q;
  logic [28:0] sin2;
  logic [57:0] qsq;
  side_r_t     side7_q;

  assign sin2 = side_a_out.n2z ? 29'd0 : quo_a;
  assign qsq  = 58'(quo_b) * 58'(quo_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else begin
      v7_q <= va && vb;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q       <= (OneRad - 58'(sin2)) << Q;
    side7_q.tir <= side_a_out.tir;
    side7_q.gt  <= side_a_out.gt;
    side7_q.c   <= side_a_out.c;
    side7_q.r0  <= sz_b ? 29'd0 : 29'(qsq >> Q);
  end

  logic        vs;
  logic [28:0] root;
  side_r_t     side_s;

  fsr_sqrt_pipe #(
    .RootW(QW),
    .SideW($bits(side_r_t))
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v7_q),
    .rad_i  (rad_q),
    .side_i (side7_q),
    .valid_o(vs),
    .root_o (root),
    .side_o (side_s)
  );

  // Stage 8: x = 1 - cos, clamped at 1.0.
  logic               v8_q, tir8_q;
  logic [28:0]        x8_q, r08_q;
  logic signed [29:0] cc, xs;

  assign cc = side_s.gt ? $signed({1'b0, root}) : side_s.c;
  assign xs = COne - cc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v8_q <= 1'b0;
    end else begin
      v8_q <= vs;
    end
  end

  always_ff @(posedge clk_i) begin
    x8_q   <= (cc <= 30'sd0) ? OneX : xs[28:0];
    r08_q  <= side_s.r0;
    tir8_q <= side_s.tir;
  end

  // Stages 9 to 12: powers of x up to the fifth.
  logic        vw_q   [4];
  logic        tirw_q [4];
  logic [28:0] pw_q   [4];
  logic [28:0] xw_q   [4];
  logic [28:0] r0w_q  [4];

  for (genvar j = 0; j < 4; j++) begin : g_pow
    logic        v_in, tir_in;
    logic [28:0] p_in, x_in, r0_in;
    logic [57:0] prod;

    if (j == 0) begin : g_head
      assign v_in   = v8_q;
      assign tir_in = tir8_q;
      assign p_in   = x8_q;
      assign x_in   = x8_q;
      assign r0_in  = r08_q;
    end else begin : g_body
      assign v_in   = vw_q[j-1];
      assign tir_in = tirw_q[j-1];
      assign p_in   = pw_q[j-1];
      assign x_in   = xw_q[j-1];
      assign r0_in  = r0w_q[j-1];
    end

    assign prod = 58'(p_in) * 58'(x_in);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vw_q[j] <= 1'b0;
      end else begin
        vw_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      pw_q[j]   <= 29'(prod >> Q);
      xw_q[j]   <= x_in;
      r0w_q[j]  <= r0_in;
      tirw_q[j] <= tir_in;
    end
  end

  // Stage 13: (1 - r0) * x^5.
  logic        v13_q, tir13_q;
  logic [28:0] term_q, r013_q;
  logic [57:0] tprod;

  assign tprod = 58'(OneX - r0w_q[3]) * 58'(pw_q[3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v13_q <= 1'b0;
    end else begin
      v13_q <= vw_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    term_q  <= 29'(tprod >> Q);
    r013_q  <= r0w_q[3];
    tir13_q <= tirw_q[3];
  end

  // Stage 14: sum, rounding and saturation.
  logic [29:0] rsum;
  logic [16:0] rnd;

  assign rsum = 30'(r013_q) + 30'(term_q);
  assign rnd  = 17'((rsum + 30'd4096) >> 13);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= v13_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_o.total_internal <= tir13_q;
    if (tir13_q || (rnd > 17'(fsr_pkg::ReflOne))) begin
      res_o.reflectance <= fsr_pkg::ReflOne;
    end else begin
      res_o.reflectance <= rnd[15:0];
    end
  end

  a_tir_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.total_internal |-> res_o.reflectance == fsr_pkg::ReflOne)
    else $error("Total internal reflection without full reflectance.");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> res_o.reflectance <= fsr_pkg::ReflOne)
    else $error("Reflectance above 1.0.");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Latency done_o)
    else $error("Request produced no result at the expected cycle.");

  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, Latency))
    else $error("Result without a matching request.");

endmodule

// ===== sim/tb.sv =====
// Testbench for fresnel_schlick_reflectance: directed and random requests,
// results checked field by field against an in-bench fixed-point predictor.
// Depends on fsr_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned Latency = 71;

  logic          clk_i;
  logic          rst_ni;
  logic          start_i;
  fsr_pkg::req_t req_i;
  logic          busy_o;
  logic          done_o;
  fsr_pkg::res_t res_o;

  fsr_pkg::req_t pending_reqs[$];
  fsr_pkg::res_t expected_refl[$];
  int            idle_pct;
  int            fail_count;

  fresnel_schlick_reflectance i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .res_o  (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bit_q;
    root  = 0;
    bit_q = 64'd1 << 62;
    while (bit_q > v) bit_q = bit_q >> 2;
    while (bit_q != 0) begin
      if (v >= root + bit_q) begin
        v    = v - (root + bit_q);
        root = (root >> 1) + bit_q;
      end else begin
        root = root >> 1;
      end
      bit_q = bit_q >> 2;
    end
    return root;
  endfunction

  function automatic fsr_pkg::res_t predict_reflectance(fsr_pkg::req_t r);
    longint        dot;
    longint        cosv;
    logic [63:0]   one;
    logic [63:0]   n1, n2, ac, s_i, lhs, rhs, sin2_t, sum, d, q, r0, x, p, term, rsum, refl;
    fsr_pkg::res_t o;
    one = 64'd1 << fsr_pkg::FracBits;
    dot = longint'(r.eye_x) * longint'(r.norm_x) + longint'(r.eye_y) * longint'(r.norm_y)
        + longint'(r.eye_z) * longint'(r.norm_z);
    if (dot > longint'(one)) dot = longint'(one);
    if (dot < -longint'(one)) dot = -longint'(one);
    cosv = dot;
    n1 = 64'(r.index_from);
    n2 = 64'(r.index_to);
    if (n1 > n2) begin
      ac  = (cosv < 0) ? 64'(-cosv) : 64'(cosv);
      s_i = ((one << fsr_pkg::FracBits) - ac * ac) >> fsr_pkg::FracBits;
      lhs = n1 * n1 * s_i;
      rhs = (n2 * n2) << fsr_pkg::FracBits;
      if (lhs > rhs) begin
        o.reflectance    = fsr_pkg::ReflOne;
        o.total_internal = 1'b1;
        return o;
      end
      sin2_t = (n2 == 0) ? 64'd0 : lhs / (n2 * n2);
      if (sin2_t > one) sin2_t = one;
      cosv = longint'(int_sqrt((one - sin2_t) << fsr_pkg::FracBits));
    end
    sum = n1 + n2;
    if (sum == 0) begin
      r0 = 0;
    end else begin
      d  = (n1 > n2) ? n1 - n2 : n2 - n1;
      q  = (d << fsr_pkg::FracBits) / sum;
      r0 = (q * q) >> fsr_pkg::FracBits;
    end
    x = 64'(longint'(one) - cosv);
    p = (x * x) >> fsr_pkg::FracBits;
    p = (p * x) >> fsr_pkg::FracBits;
    p = (p * x) >> fsr_pkg::FracBits;
    p = (p * x) >> fsr_pkg::FracBits;
    term = ((one - r0) * p) >> fsr_pkg::FracBits;
    rsum = r0 + term;
    refl = (rsum + (64'd1 << 12)) >> 13;
    if (refl > 64'd32768) refl = 64'd32768;
    o.reflectance    = refl[15:0];
    o.total_internal = 1'b0;
    return o;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic queue_req(fsr_pkg::req_t r);
    pending_reqs = {pending_reqs, r};
  endtask

  // Driver: records the expected result of each taken request, then offers the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      req_i   <= '0;
    end else begin
      if (start_i && !busy_o) expected_refl = {expected_refl, predict_reflectance(req_i)};
      if (start_i && busy_o) begin
        start_i <= 1'b1;
      end else if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
        req_i   <= pending_reqs.pop_front();
        start_i <= 1'b1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: each strobed result is compared with the oldest expectation.
  always @(posedge clk_i) begin
    fsr_pkg::res_t want;
    if (rst_ni && done_o) begin
      if (expected_refl.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = expected_refl.pop_front();
        if (res_o.reflectance !== want.reflectance)
          report_mismatch($sformatf("reflectance %0d, expected %0d",
                                    res_o.reflectance, want.reflectance));
        if (res_o.total_internal !== want.total_internal)
          report_mismatch($sformatf("total_internal %0b, expected %0b",
                                    res_o.total_internal, want.total_internal));
      end
    end
  end

  function automatic logic signed [15:0] to_q14(real v);
    return 16'($rtoi(v * 16384.0 + ((v >= 0.0) ? 0.5 : -0.5)));
  endfunction

  function automatic fsr_pkg::req_t random_req();
    fsr_pkg::req_t r;
    real           a[6];
    real           len_e, len_n;
    for (int k = 0; k < 6; k++) a[k] = ($itor($urandom_range(20000)) - 10000.0) / 10000.0;
    len_e = $sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]) + 1.0e-6;
    len_n = $sqrt(a[3] * a[3] + a[4] * a[4] + a[5] * a[5]) + 1.0e-6;
    r.eye_x  = to_q14(a[0] / len_e);
    r.eye_y  = to_q14(a[1] / len_e);
    r.eye_z  = to_q14(a[2] / len_e);
    r.norm_x = to_q14(a[3] / len_n);
    r.norm_y = to_q14(a[4] / len_n);
    r.norm_z = to_q14(a[5] / len_n);
    if ($urandom_range(9) == 0) begin
      r.eye_x  = 16'($urandom);
      r.norm_x = 16'($urandom);
      r.eye_y  = 16'($urandom);
      r.norm_z = 16'($urandom);
    end
    if ($urandom_range(4) == 0) begin
      r.index_from = 15'($urandom);
      r.index_to   = 15'($urandom);
    end else begin
      r.index_from = 15'($urandom_range(4096, 10240));
      r.index_to   = 15'($urandom_range(4096, 10240));
    end
    return r;
  endfunction

  function automatic fsr_pkg::req_t make_req(int ex, int ey, int ez, int nx, int ny, int nz,
                                             int n1, int n2);
    fsr_pkg::req_t r;
    r.eye_x      = 16'(ex);
    r.eye_y      = 16'(ey);
    r.eye_z      = 16'(ez);
    r.norm_x     = 16'(nx);
    r.norm_y     = 16'(ny);
    r.norm_z     = 16'(nz);
    r.index_from = 15'(n1);
    r.index_to   = 15'(n2);
    return r;
  endfunction

  task automatic drain();
    wait (pending_reqs.size() == 0 && !start_i && expected_refl.size() == 0);
    @(posedge clk_i);
  endtask

  initial begin
    fail_count = 0;
    idle_pct   = 12;
    rst_ni     = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    queue_req(make_req(16384, 0, 0, 16384, 0, 0, 4096, 6144));
    queue_req(make_req(16384, 0, 0, -16384, 0, 0, 4096, 6144));
    queue_req(make_req(0, -16384, 0, 0, -16384, 0, 6144, 4096));
    queue_req(make_req(0, 0, 16384, 16384, 0, 0, 6144, 4096));
    queue_req(make_req(11585, 0, 11585, 0, 0, 16384, 6144, 4096));
    queue_req(make_req(16000, 0, 3530, 0, 0, 16384, 6144, 4096));
    queue_req(make_req(32767, 32767, 32767, 32767, 32767, 32767, 5000, 7000));
    queue_req(make_req(-32768, -32768, -32768, 32767, 32767, 32767, 5000, 4500));
    queue_req(make_req(-32768, 0, 0, -32768, 0, 0, 32767, 4096));
    queue_req(make_req(9459, 9459, 9459, 9459, 9459, 9459, 5461, 5461));
    queue_req(make_req(16384, 0, 0, 0, 16384, 0, 0, 0));
    queue_req(make_req(16384, 0, 0, 16384, 0, 0, 4096, 0));
    queue_req(make_req(16384, 0, 0, 8192, 0, 0, 4096, 0));
    queue_req(make_req(16384, 0, 0, 16384, 0, 0, 32767, 32767));
    queue_req(make_req(16384, 0, 0, 16384, 0, 0, 4096, 32767));
    queue_req(make_req(0, 16384, 0, 0, 16384, 0, 32767, 4096));
    queue_req(make_req(0, 16384, 0, 16384, 0, 0, 4096, 32767));
    queue_req(make_req(-1, -1, -1, -1, -1, -1, 1, 32767));
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 12 : (phase == 1) ? 85 : 0;
      for (int k = 0; k < 135; k++) queue_req(random_req());
      drain();
    end

    repeat (Latency + 20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/fsr_pkg.sv
rtl/core/fsr_div_pipe.sv
rtl/core/fsr_sqrt_pipe.sv
rtl/core/fresnel_schlick_reflectance.sv
sim/tb.sv
